>>> sv/tun_pkg.sv
`timescale 1ns / 1ps
package tun_pkg;
    localparam int unsigned OUT_W = 16;
    localparam int unsigned MAG_W = 31;
    localparam int unsigned SUM_W = 64;
    localparam int unsigned ROOT_W = 32;
    localparam int unsigned QUO_W = 16;
    localparam logic [OUT_W-1:0] OUT_MAX = 16'd32767;
endpackage

>>> sv/tun_if.sv
`timescale 1ns / 1ps
interface tun_tri_if #(parameter int COORD_WIDTH = 16) (input logic i_clk);
    logic valid;
    logic ready;
    logic signed [COORD_WIDTH-1:0] vertex_a_x, vertex_a_y, vertex_a_z;
    logic signed [COORD_WIDTH-1:0] vertex_b_x, vertex_b_y, vertex_b_z;
    logic signed [COORD_WIDTH-1:0] vertex_c_x, vertex_c_y, vertex_c_z;
    modport source (output valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x,
        vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, input ready);
    modport sink (input valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x,
        vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, output ready);
endinterface

interface tun_nrm_if (input logic i_clk);
    logic valid;
    logic ready;
    logic signed [15:0] normal_x, normal_y, normal_z;
    modport source (output valid, normal_x, normal_y, normal_z, input ready);
    modport sink (input valid, normal_x, normal_y, normal_z, output ready);
endinterface

>>> sv/tun_div_stage.sv
`timescale 1ns / 1ps
module tun_div_stage #(
    parameter int W = 48,
    parameter int BITS = 4,
    parameter int DW = 32
) (
    input  logic [W-1:0]  i_rem,
    input  logic [DW-1:0] i_den,
    input  logic [BITS-1:0] i_q,
    input  logic [W-1:0]  i_num,
    output logic [W-1:0]  o_rem,
    output logic [W-1:0]  o_num,
    output logic [BITS-1:0] o_q
);
    // restoring division, BITS quotient bits per stage, numerator shifted in msb first
    logic [W:0] rem;
    logic [W-1:0] num;
    logic [BITS-1:0] q;
    always_comb begin
        rem = {1'b0, i_rem};
        num = i_num;
        q = i_q;
        for (int k = 0; k < BITS; k++) begin
            rem = {rem[W-1:0], num[W-1]};
            num = {num[W-2:0], 1'b0};
            if (rem >= {{(W+1-DW){1'b0}}, i_den}) begin
                rem = rem - {{(W+1-DW){1'b0}}, i_den};
                q = {q[BITS-2:0], 1'b1};
            end else begin
                q = {q[BITS-2:0], 1'b0};
            end
        end
        o_rem = rem[W-1:0];
        o_num = num;
        o_q = q;
    end
endmodule

>>> sv/triangle_unit_normal_top.sv
`timescale 1ns / 1ps
// channel   dir  payload
// tri       in   vertex_{a,b,c}_{x,y,z}, COORD_WIDTH bits signed q8.8
// nrm       out  normal_{x,y,z}, 16 bits signed q1.15
// one triangle per cycle while the output is not stalled; the pipeline holds the 16-stage root (2 bits/stage)
// and the 12-stage divider (4 bits/stage, three lanes) plus six front stages
// synchronous active-low reset clears the valid bits only
// a stall on the output holds the whole pipeline in place; the final register
// and skid register let a new transaction enter while a result waits
module triangle_unit_normal_top #(
    parameter int COORD_WIDTH = 16
) (
    input logic i_clk,
    input logic i_rst_n,
    tun_tri_if.sink i_tri,
    tun_nrm_if.source o_nrm
);
    import tun_pkg::*;
    localparam int EW = COORD_WIDTH + 1;
    localparam int PW = 2 * EW;
    localparam int NW = PW + 1;
    localparam int BLW = $clog2(NW + 1);
    localparam int NSQ = 16;
    localparam int NDV = 12;
    localparam int DNW = 48;
    localparam int NST = 6 + NSQ + NDV;

    logic [NST-1:0] r_v;
    logic adv;
    logic r_skv;
    assign adv = !r_v[NST-1] || !r_skv;
    assign i_tri.ready = adv;

    // s0 edges
    logic signed [EW-1:0] r_e1[3], r_e2[3];
    always_ff @(posedge i_clk) if (adv) begin
        r_e1[0] <= EW'(i_tri.vertex_b_x) - EW'(i_tri.vertex_a_x);
        r_e1[1] <= EW'(i_tri.vertex_b_y) - EW'(i_tri.vertex_a_y);
        r_e1[2] <= EW'(i_tri.vertex_b_z) - EW'(i_tri.vertex_a_z);
        r_e2[0] <= EW'(i_tri.vertex_c_x) - EW'(i_tri.vertex_a_x);
        r_e2[1] <= EW'(i_tri.vertex_c_y) - EW'(i_tri.vertex_a_y);
        r_e2[2] <= EW'(i_tri.vertex_c_z) - EW'(i_tri.vertex_a_z);
    end
    // s1 products
    logic signed [PW-1:0] r_p[6];
    always_ff @(posedge i_clk) if (adv) begin
        r_p[0] <= PW'(r_e1[1]) * PW'(r_e2[2]);
        r_p[1] <= PW'(r_e1[2]) * PW'(r_e2[1]);
        r_p[2] <= PW'(r_e1[2]) * PW'(r_e2[0]);
        r_p[3] <= PW'(r_e1[0]) * PW'(r_e2[2]);
        r_p[4] <= PW'(r_e1[0]) * PW'(r_e2[1]);
        r_p[5] <= PW'(r_e1[1]) * PW'(r_e2[0]);
    end
    // s2 cross and magnitudes
    logic [NW-1:0] r_m[3];
    logic [2:0] r_sg2;
    always_ff @(posedge i_clk) if (adv) begin
        for (int i = 0; i < 3; i++) begin
            logic signed [NW-1:0] n;
            n = NW'(r_p[2*i]) - NW'(r_p[2*i+1]);
            r_m[i] <= n[NW-1] ? NW'(-n) : NW'(n);
            r_sg2[i] <= n[NW-1];
        end
    end
    // s3 bit length
    logic [NW-1:0] r_m3[3];
    logic [BLW-1:0] r_bl;
    always_ff @(posedge i_clk) if (adv) begin
        logic [NW-1:0] o;
        logic [BLW-1:0] b;
        o = r_m[0] | r_m[1] | r_m[2];
        b = '0;
        for (int k = 0; k < NW; k++) if (o[k]) b = BLW'(k + 1);
        r_bl <= b;
        r_m3 <= r_m;
    end
    // s4 normalize to 31 bits
    logic [MAG_W-1:0] r_n4[3];
    logic r_zero4;
    always_ff @(posedge i_clk) if (adv) begin
        r_zero4 <= (r_bl == '0);
        for (int i = 0; i < 3; i++) begin
            logic [NW+MAG_W-1:0] t;
            t = {{MAG_W{1'b0}}, r_m3[i]};
            if (r_bl > BLW'(MAG_W)) t = t >> (r_bl - BLW'(MAG_W));
            else t = t << (BLW'(MAG_W) - r_bl);
            r_n4[i] <= t[MAG_W-1:0];
        end
    end
    // s5 squares
    logic [SUM_W-1:0] r_sum;
    always_ff @(posedge i_clk) if (adv) begin
        r_sum <= SUM_W'(r_n4[0]) * SUM_W'(r_n4[0]) + SUM_W'(r_n4[1]) * SUM_W'(r_n4[1])
               + SUM_W'(r_n4[2]) * SUM_W'(r_n4[2]);
    end
    // root: 2 result bits per stage
    logic [SUM_W-1:0] r_sq_v[NSQ], r_sq_r[NSQ];
    for (genvar s = 0; s < NSQ; s++) begin : g_sq
        logic [SUM_W-1:0] v_in, r_in;
        if (s == 0) begin : g_first
            assign v_in = r_sum;
            assign r_in = '0;
        end else begin : g_next
            assign v_in = r_sq_v[s-1];
            assign r_in = r_sq_r[s-1];
        end
        always_ff @(posedge i_clk) if (adv) begin
            logic [SUM_W-1:0] v, r, bt;
            v = v_in;
            r = r_in;
            for (int k = 0; k < 2; k++) begin
                bt = SUM_W'(1) << (62 - 2 * (2 * s + k));
                if (v >= r + bt) begin
                    v = v - (r + bt);
                    r = (r >> 1) + bt;
                end else r = r >> 1;
            end
            r_sq_v[s] <= v;
            r_sq_r[s] <= r;
        end
    end
    // carry normalized mags, sign, zero along
    logic [2:0] r_sg[3:NST-1];
    logic r_zero[5:NST-1];
    logic [MAG_W-1:0] r_n[5:5+NSQ][3];
    always_ff @(posedge i_clk) if (adv) begin
        r_sg[3] <= r_sg2;
        for (int s = 4; s < NST; s++) r_sg[s] <= r_sg[s-1];
        r_zero[5] <= r_zero4;
        for (int s = 6; s < NST; s++) r_zero[s] <= r_zero[s-1];
        r_n[5] <= r_n4;
        for (int s = 6; s <= 5 + NSQ; s++) r_n[s] <= r_n[s-1];
    end
    // divider lanes
    logic [ROOT_W-1:0] len;
    assign len = r_sq_r[NSQ-1][ROOT_W-1:0];
    logic [DNW-1:0] r_dr[NDV][3], r_dn[NDV][3];
    logic [ROOT_W-1:0] r_dd[NDV];
    logic [QUO_W+3:0] r_dq[NDV][3];
    for (genvar s = 0; s < NDV; s++) begin : g_dv
        logic [ROOT_W-1:0] den;
        if (s == 0) begin : g_first
            assign den = len;
        end else begin : g_next
            assign den = r_dd[s-1];
        end
        for (genvar i = 0; i < 3; i++) begin : g_ln
            logic [DNW-1:0] ir, in_, orr, on;
            logic [3:0] oq;
            logic [QUO_W+3:0] nq;
            if (s == 0) begin : g_first
                assign ir = '0;
                assign in_ = DNW'({r_n[5+NSQ][i], 15'b0}) + DNW'(len >> 1);
                assign nq = {{QUO_W{1'b0}}, oq};
            end else begin : g_next
                assign ir = r_dr[s-1][i];
                assign in_ = r_dn[s-1][i];
                assign nq = {r_dq[s-1][i][QUO_W-1:0], oq};
            end
            tun_div_stage #(.W(DNW), .BITS(4), .DW(ROOT_W)) u_st (
                .i_rem(ir), .i_den(den), .i_q(4'b0), .i_num(in_),
                .o_rem(orr), .o_num(on), .o_q(oq)
            );
            always_ff @(posedge i_clk) if (adv) begin
                r_dr[s][i] <= orr;
                r_dn[s][i] <= on;
                r_dq[s][i] <= nq;
            end
        end
        always_ff @(posedge i_clk) if (adv) r_dd[s] <= den;
    end
    // valid chain and output with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (adv) r_v <= {r_v[NST-2:0], i_tri.valid};
    end
    logic signed [OUT_W-1:0] res[3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [QUO_W-1:0] q;
            logic [QUO_W+3:0] f;
            f = r_dq[NDV-1][i];
            q = (f > (QUO_W+4)'(OUT_MAX)) ? OUT_MAX : f[QUO_W-1:0];
            if (r_zero[NST-1]) q = '0;
            res[i] = r_sg[NST-1][i] ? -$signed(q) : $signed(q);
        end
    end
    logic signed [OUT_W-1:0] r_sk[3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_skv <= 1'b0;
        else if (!r_skv && r_v[NST-1] && !o_nrm.ready) r_skv <= 1'b1;
        else if (r_skv && o_nrm.ready) r_skv <= 1'b0;
    end
    always_ff @(posedge i_clk) if (!r_skv) r_sk <= res;
    assign o_nrm.valid = r_skv || r_v[NST-1];
    assign o_nrm.normal_x = r_skv ? r_sk[0] : res[0];
    assign o_nrm.normal_y = r_skv ? r_sk[1] : res[1];
    assign o_nrm.normal_z = r_skv ? r_sk[2] : res[2];
endmodule

>>> sv/triangle_unit_normal_chk.sv
`timescale 1ns / 1ps
module triangle_unit_normal_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic ov, ordy,
    input logic signed [15:0] nx, ny, nz
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ov && !ordy |=> ov && $stable(nx) && $stable(ny) && $stable(nz))
        else $error("output changed under stall");
    a_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ov |-> nx != -16'sd32768 && ny != -16'sd32768 && nz != -16'sd32768)
        else $error("normal out of range");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !ov)
        else $error("valid after reset");
endmodule

bind triangle_unit_normal_top triangle_unit_normal_chk u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .ov(o_nrm.valid), .ordy(o_nrm.ready),
    .nx(o_nrm.normal_x), .ny(o_nrm.normal_y), .nz(o_nrm.normal_z)
);

>>> tb/tun_checker.sv
`timescale 1ns / 1ps
module tun_checker #(
    parameter int COORD_WIDTH = 16
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_tri_valid,
    input logic i_tri_ready,
    input logic [9*COORD_WIDTH-1:0] i_tri_payload,
    input logic i_nrm_valid,
    input logic i_nrm_ready,
    input logic signed [15:0] i_nrm_x,
    input logic signed [15:0] i_nrm_y,
    input logic signed [15:0] i_nrm_z,
    output int o_fail_count,
    output int o_pending,
    output int o_checked
);
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } normal_t;

    normal_t normal_queue[$];

    function automatic longint coord(input logic [9*COORD_WIDTH-1:0] p, input int idx);
        logic signed [COORD_WIDTH-1:0] v;
        v = p[idx*COORD_WIDTH +: COORD_WIDTH];
        return longint'(v);
    endfunction

    function automatic longint unsigned int_root(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic normal_t face_normal(input logic [9*COORD_WIDTH-1:0] p);
        longint ax, ay, az, e1x, e1y, e1z, e2x, e2y, e2z;
        longint n[3];
        longint unsigned m[3];
        longint unsigned big, sum, len, q;
        int nbits;
        logic [15:0] r[3];
        normal_t res;
        ax = coord(p, 0); ay = coord(p, 1); az = coord(p, 2);
        e1x = coord(p, 3) - ax; e1y = coord(p, 4) - ay; e1z = coord(p, 5) - az;
        e2x = coord(p, 6) - ax; e2y = coord(p, 7) - ay; e2z = coord(p, 8) - az;
        n[0] = e1y * e2z - e1z * e2y;
        n[1] = e1z * e2x - e1x * e2z;
        n[2] = e1x * e2y - e1y * e2x;
        big = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = (n[i] < 0) ? longint'(-n[i]) : longint'(n[i]);
            if (m[i] > big) big = m[i];
        end
        if (big == 0) return '0;
        nbits = 0;
        while ((big >> nbits) != 0) nbits++;
        for (int i = 0; i < 3; i++) begin
            if (nbits > 31) m[i] = m[i] >> (nbits - 31);
            else m[i] = m[i] << (31 - nbits);
        end
        sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len = int_root(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << 15) + (len >> 1)) / len;
            if (q > 32767) q = 32767;
            if (n[i] < 0) q = -q;
            r[i] = q[15:0];
        end
        res.x = r[0]; res.y = r[1]; res.z = r[2];
        return res;
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_checked = 0;
    end

    assign o_pending = normal_queue.size();

    always @(posedge i_clk) begin
        normal_t want;
        if (i_rst_n && i_tri_valid && i_tri_ready)
            normal_queue.push_back(face_normal(i_tri_payload));
        if (i_rst_n && i_nrm_valid && i_nrm_ready) begin
            o_checked++;
            if (normal_queue.size() == 0) begin
                report("unexpected transaction", 0, 0);
            end else begin
                want = normal_queue.pop_front();
                if (i_nrm_x !== want.x) report("normal_x", i_nrm_x, want.x);
                if (i_nrm_y !== want.y) report("normal_y", i_nrm_y, want.y);
                if (i_nrm_z !== want.z) report("normal_z", i_nrm_z, want.z);
            end
        end
    end
endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    localparam int CW = 16;
    localparam int RANDOM_ITEMS = 2000;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int fail_count, pending, checked, cycle_count, sent;
    logic [9*CW-1:0] payload;

    tun_tri_if #(.COORD_WIDTH(CW)) tri_ch (i_clk);
    tun_nrm_if nrm_ch (i_clk);

    triangle_unit_normal_top #(.COORD_WIDTH(CW)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_tri(tri_ch.sink), .o_nrm(nrm_ch.source)
    );

    assign payload = {tri_ch.vertex_c_z, tri_ch.vertex_c_y, tri_ch.vertex_c_x,
                      tri_ch.vertex_b_z, tri_ch.vertex_b_y, tri_ch.vertex_b_x,
                      tri_ch.vertex_a_z, tri_ch.vertex_a_y, tri_ch.vertex_a_x};

    tun_checker #(.COORD_WIDTH(CW)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_tri_valid(tri_ch.valid), .i_tri_ready(tri_ch.ready), .i_tri_payload(payload),
        .i_nrm_valid(nrm_ch.valid), .i_nrm_ready(nrm_ch.ready),
        .i_nrm_x(nrm_ch.normal_x), .i_nrm_y(nrm_ch.normal_y), .i_nrm_z(nrm_ch.normal_z),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("status: fail");
            $finish;
        end
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver stalls, with calm stretches
    initial begin
        nrm_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if ($urandom_range(0, 9) < 3) begin
                nrm_ch.ready <= 1'b1;
                repeat ($urandom_range(20, 80)) @(posedge i_clk);
            end else begin
                nrm_ch.ready <= ($urandom_range(0, 3) != 0);
                repeat (1 + (($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : 0))
                    @(posedge i_clk);
            end
        end
    end

    task automatic send_triangle(input logic [9*CW-1:0] v);
        {tri_ch.vertex_c_z, tri_ch.vertex_c_y, tri_ch.vertex_c_x,
         tri_ch.vertex_b_z, tri_ch.vertex_b_y, tri_ch.vertex_b_x,
         tri_ch.vertex_a_z, tri_ch.vertex_a_y, tri_ch.vertex_a_x} <= v;
        tri_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!tri_ch.ready) @(posedge i_clk);
        sent++;
        if (sent % 4 == 0 || $urandom_range(0, 1) == 0) begin
            int g;
            g = gap_length();
            if (g > 0) begin
                tri_ch.valid <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
    endtask

    function automatic logic [CW-1:0] rand_coord(input int style);
        case (style)
            0: return CW'($urandom());
            1: return CW'($urandom_range(0, 255) - 128);
            2: return ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
            default: return CW'($urandom_range(0, 15));
        endcase
    endfunction

    function automatic logic [9*CW-1:0] rand_triangle();
        logic [9*CW-1:0] v;
        int style, kind;
        style = $urandom_range(0, 9);
        style = (style < 5) ? 0 : (style < 7) ? 1 : (style < 8) ? 2 : 3;
        for (int i = 0; i < 9; i++) begin
            v[i*CW +: CW] = ($urandom_range(0, 4) == 0) ? rand_coord($urandom_range(0, 3))
                                                        : rand_coord(style);
        end
        kind = $urandom_range(0, 19);
        // degenerate shapes: repeated vertex or collinear points
        if (kind == 0) v[3*CW +: 3*CW] = v[0 +: 3*CW];
        if (kind == 1) v[6*CW +: 3*CW] = v[3*CW +: 3*CW];
        if (kind == 2) for (int i = 0; i < 3; i++)
            v[(6+i)*CW +: CW] = CW'(2 * v[(3+i)*CW +: CW] - v[i*CW +: CW]);
        return v;
    endfunction

    initial begin
        logic [CW-1:0] mx, mn;
        tri_ch.valid = 1'b0;
        {tri_ch.vertex_a_x, tri_ch.vertex_a_y, tri_ch.vertex_a_z} = '0;
        {tri_ch.vertex_b_x, tri_ch.vertex_b_y, tri_ch.vertex_b_z} = '0;
        {tri_ch.vertex_c_x, tri_ch.vertex_c_y, tri_ch.vertex_c_z} = '0;
        cycle_count = 0;
        sent = 0;
        mx = 16'h7fff;
        mn = 16'h8000;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero, degenerate, axis normals, saturation, extremes
        send_triangle('0);
        send_triangle({3{16'h0100, 16'h0200, 16'h0300}});
        send_triangle({16'd0, 16'h0100, 16'd0, 16'd0, 16'd0, 16'h0100, 48'd0});
        send_triangle({16'd0, 16'd0, 16'h0100, 16'd0, 16'h0100, 16'd0, 48'd0});
        send_triangle({16'h0100, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0100, 48'd0});
        send_triangle({16'd0, 16'd0, 16'h0100, 16'h0100, 16'd0, 16'd0, 48'd0});
        send_triangle({16'd0, 16'd1, 16'd0, 16'd1, 16'd0, 16'd0, 48'd0});
        send_triangle({16'd0, mx, mx, mx, mx, 16'd0, mn, mn, mn});
        send_triangle({mn, mx, mn, mx, mn, mx, mn, mn, mn});
        send_triangle({mx, mn, mx, mn, mx, mn, mx, mx, mx});
        send_triangle({mx, mx, mn, mn, mx, mx, mx, mn, mx});
        send_triangle({mn, mn, mx, mx, mn, mn, 16'd0, 16'd0, 16'd0});
        send_triangle({16'd3, 16'd5, 16'd7, 16'd11, 16'd13, 16'd17, 16'd0, 16'd0, 16'd0});
        send_triangle({16'hffff, 16'h0001, 16'h5555, 16'haaaa, 16'h1234, 16'hedcb,
                       16'h0f0f, 16'hf0f0, 16'h8001});

        tri_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_triangle(rand_triangle());
            if (n == RANDOM_ITEMS / 2) begin
                tri_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
        end
        tri_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("sent %0d triangles, checked %0d normals incl. degenerate,", sent, checked);
        $display("saturating and full-range coordinate cases under random stalls");
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
